// ===== hw/rtl/cpfdr_pkg.sv =====
package cpfdr_pkg;

  localparam int unsigned InLabelW = 16;
  localparam int unsigned RateW    = 17;
  localparam int unsigned PairW    = 19;
  localparam int unsigned StepW    = 5;

  localparam logic [PairW-1:0] PairMax  = '1;
  localparam logic [StepW-1:0] StepLast = StepW'(RateW - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/clustering_pair_fdr_fnr_top.sv =====
// Pair-counting comparison of two clusterings. Each request carries one element (estimated
// label, reference label, last mark); the element is stored and compared with every earlier
// element of the sequence, one stored element per cycle through a single-read-port label
// memory; a request holds the input while the n elements already stored (at most
// MAX_ITEMS) are compared. On the last request a serial restoring divider works out FDR
// and FNR at one quotient bit per cycle, then the result register is loaded and the
// counts clear. Elements beyond MAX_ITEMS are dropped and flagged in the result.
// Labels are compared on their low min(LABEL_BITS, 16) bits; pair counts saturate at 524287.
module clustering_pair_fdr_fnr_top #(
  parameter int unsigned MAX_ITEMS  = 1024,
  parameter int unsigned LABEL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cpfdr_pkg::InLabelW-1:0]  est_label_i,
  input  logic [cpfdr_pkg::InLabelW-1:0]  ref_label_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cpfdr_pkg::RateW-1:0]     false_discovery_o,
  output logic [cpfdr_pkg::RateW-1:0]     false_negative_rate_o,
  output logic [cpfdr_pkg::PairW-1:0]     true_pairs_o,
  output logic [cpfdr_pkg::PairW-1:0]     false_pairs_o,
  output logic [cpfdr_pkg::PairW-1:0]     missed_pairs_o,
  output logic                            overflowed_o
);
  import cpfdr_pkg::*;

  localparam int unsigned SW    = (LABEL_BITS < InLabelW) ? LABEL_BITS : InLabelW;
  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = (2 * IDX_W > PairW + 1) ? 2 * IDX_W : PairW + 1;
  localparam int unsigned RW    = CNT_W + 1;
  localparam logic [IDX_W:0] CountFull = (IDX_W + 1)'(MAX_ITEMS);

  logic [SW-1:0] est_mem [MAX_ITEMS];
  logic [SW-1:0] ref_mem [MAX_ITEMS];

  state_e state_q;
  logic   in_acc, out_acc, mem_we, out_load;

  logic [SW-1:0]    est_q, ref_q, rd_est_q, rd_ref_q;
  logic             last_q, pend_q, ovf_q, div_sel_q, den_zero_q;
  logic [IDX_W:0]   count_q, idx_q, scan_n_q;
  logic [CNT_W-1:0] tp_q, fp_q, fn_q;
  logic [RW-1:0]    rem_q, den_q, rem_d;
  logic [RW:0]      div_t, div_r;
  logic             div_ge;
  logic [RateW-1:0] quo_q, quo_d, div_res, fdr_q, fnr_q;
  logic [StepW-1:0] step_q;
  logic             se, sr;

  logic             out_valid_q, ovf_out_q;
  logic [RateW-1:0] fdr_out_q, fnr_out_q;
  logic [PairW-1:0] tp_out_q, fp_out_q, fn_out_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_acc    = out_valid_q && !out_stall_i;
  assign mem_we     = in_acc && (count_q != CountFull);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      est_mem[count_q[IDX_W-1:0]] <= est_label_i[SW-1:0];
      ref_mem[count_q[IDX_W-1:0]] <= ref_label_i[SW-1:0];
    end
    rd_est_q <= est_mem[idx_q[IDX_W-1:0]];
    rd_ref_q <= ref_mem[idx_q[IDX_W-1:0]];
  end

  assign se = (rd_est_q == est_q);
  assign sr = (rd_ref_q == ref_q);

  always_comb begin
    div_t   = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    div_ge  = (div_t >= {1'b0, den_q});
    div_r   = div_ge ? (div_t - {1'b0, den_q}) : div_t;
    rem_d   = div_r[RW-1:0];
    quo_d   = {quo_q[RateW-2:0], div_ge};
    div_res = den_zero_q ? '0 : quo_d;
  end

  function automatic logic [PairW-1:0] sat_pairs(input logic [CNT_W-1:0] v);
    logic [PairW-1:0] r;
    r = (v > CNT_W'(PairMax)) ? PairMax : v[PairW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      est_q       <= '0;
      ref_q       <= '0;
      last_q      <= 1'b0;
      pend_q      <= 1'b0;
      ovf_q       <= 1'b0;
      div_sel_q   <= 1'b0;
      den_zero_q  <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      scan_n_q    <= '0;
      tp_q        <= '0;
      fp_q        <= '0;
      fn_q        <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      fdr_q       <= '0;
      fnr_q       <= '0;
      out_valid_q <= 1'b0;
      ovf_out_q   <= 1'b0;
      fdr_out_q   <= '0;
      fnr_out_q   <= '0;
      tp_out_q    <= '0;
      fp_out_q    <= '0;
      fn_out_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            est_q  <= est_label_i[SW-1:0];
            ref_q  <= ref_label_i[SW-1:0];
            last_q <= last_i;
            idx_q  <= '0;
            pend_q <= 1'b0;
            if (count_q == CountFull) begin
              ovf_q    <= 1'b1;
              scan_n_q <= '0;
            end else begin
              scan_n_q <= count_q;
              count_q  <= count_q + 1'b1;
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q != scan_n_q) begin
            idx_q  <= idx_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            if (se && sr) begin
              tp_q <= tp_q + 1'b1;
            end else if (se) begin
              fp_q <= fp_q + 1'b1;
            end else if (sr) begin
              fn_q <= fn_q + 1'b1;
            end
          end
          if ((idx_q == scan_n_q) && !pend_q) begin
            if (last_q) begin
              rem_q      <= {1'b0, fp_q};
              den_q      <= {1'b0, tp_q} + {1'b0, fp_q};
              den_zero_q <= (tp_q == '0) && (fp_q == '0);
              div_sel_q  <= 1'b0;
              step_q     <= '0;
              quo_q      <= '0;
              state_q    <= ST_DIV;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          if (step_q == StepLast) begin
            step_q <= '0;
            quo_q  <= '0;
            if (!div_sel_q) begin
              fdr_q      <= div_res;
              rem_q      <= {1'b0, fn_q};
              den_q      <= {1'b0, tp_q} + {1'b0, fn_q};
              den_zero_q <= (tp_q == '0) && (fn_q == '0);
              div_sel_q  <= 1'b1;
            end else begin
              fnr_q   <= div_res;
              state_q <= ST_DONE;
            end
          end else begin
            rem_q  <= rem_d;
            quo_q  <= quo_d;
            step_q <= step_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            fdr_out_q   <= fdr_q;
            fnr_out_q   <= fnr_q;
            tp_out_q    <= sat_pairs(tp_q);
            fp_out_q    <= sat_pairs(fp_q);
            fn_out_q    <= sat_pairs(fn_q);
            ovf_out_q   <= ovf_q;
            count_q     <= '0;
            tp_q        <= '0;
            fp_q        <= '0;
            fn_q        <= '0;
            ovf_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o           = out_valid_q;
  assign false_discovery_o     = fdr_out_q;
  assign false_negative_rate_o = fnr_out_q;
  assign true_pairs_o          = tp_out_q;
  assign false_pairs_o         = fp_out_q;
  assign missed_pairs_o        = fn_out_q;
  assign overflowed_o          = ovf_out_q;

endmodule
